/* sv/ps2hlc_pkg.sv */
// shared types and codes for the ps/2 host line controller
// used by the step unit and the top level
// no dependencies

package ps2hlc_pkg;

  // input beat commands
  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_SEND = 2'd2;

  // result event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_BYTE      = 3'd1;
  localparam logic [2:0] EV_SEND_OK   = 3'd2;
  localparam logic [2:0] EV_SEND_FAIL = 3'd3;
  localparam logic [2:0] EV_BUSY      = 3'd4;
  localparam logic [2:0] EV_ABORT     = 3'd5;

  // line phases
  localparam logic [1:0] PH_RECEIVE = 2'd0;
  localparam logic [1:0] PH_INHIBIT = 2'd1;
  localparam logic [1:0] PH_SEND    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INHIBIT       = 2'd0;
  localparam logic [1:0] REG_BIT_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_START_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd3;

  // configuration reset values
  localparam logic [15:0] INHIBIT_RESET       = 16'd300;
  localparam logic [15:0] BIT_TIMEOUT_RESET   = 16'd550;
  localparam logic [15:0] START_TIMEOUT_RESET = 16'd10000;
  localparam logic [3:0]  MAX_ATTEMPTS_RESET  = 4'd5;

  // frame positions
  localparam logic [3:0] POS_PARITY = 4'd9;
  localparam logic [3:0] POS_STOP   = 4'd10;
  localparam logic [3:0] POS_ACK    = 4'd11;

  typedef struct packed {
    logic [15:0] inhibit_ticks;
    logic [15:0] bit_timeout_ticks;
    logic [15:0] start_timeout_ticks;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] received_value;
    logic       clock_drive_low;
    logic       data_drive_low;
    logic       busy_res;
  } result_t;

endpackage

/* sv/ps2hlc_if.sv */
// valid/ready channel interfaces for the ps/2 host line controller
// request channel carries line events and send commands, result channel carries events and line drive
// no dependencies

interface ps2hlc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       data_line;
  logic [7:0] send_value;

  modport source (output valid, output command, output data_line, output send_value,
                  input ready);
  modport sink (input valid, input command, input data_line, input send_value,
                output ready);
endinterface

interface ps2hlc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] received_value;
  logic       clock_drive_low;
  logic       data_drive_low;
  logic       busy_res;

  modport source (output valid, output event_res, output received_value,
                  output clock_drive_low, output data_drive_low, output busy_res,
                  input ready);
  modport sink (input valid, input event_res, input received_value,
                input clock_drive_low, input data_drive_low, input busy_res,
                output ready);
endinterface

/* sv/ps2hlc_step.sv */
// line state and per-beat step logic of the ps/2 host line controller
// holds receive and send framing, countdown and retry count
// depends on ps2hlc_pkg

module ps2hlc_step #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ps2hlc_pkg::cfg_t    cfg,
  input  logic                step,
  input  logic [1:0]          command,
  input  logic                data_line,
  input  logic [7:0]          send_value,
  output ps2hlc_pkg::result_t result
);
  import ps2hlc_pkg::*;

  localparam int WIDE = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [1:0]             phase, phase_next;
  logic [3:0]             receive_position, receive_position_next;
  logic [7:0]             receive_shift, receive_shift_next;
  logic [3:0]             send_position, send_position_next;
  logic [7:0]             send_shift, send_shift_next;
  logic [TIMER_WIDTH-1:0] countdown, countdown_next;
  logic                   countdown_active, countdown_active_next;
  logic [3:0]             attempts_done, attempts_done_next;
  logic                   clock_low_reg, clock_low_next;
  logic                   data_low_reg, data_low_next;

  logic [2:0]             ev;
  logic [7:0]             rx;
  logic                   fail;
  logic [3:0]             att_inc;
  logic [TIMER_WIDTH-1:0] load_inhibit, load_bit, load_start;

  // saturate a 16-bit tick count into the countdown width
  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [15:0] ticks);
    logic [WIDE-1:0] ticks_w;
    logic [WIDE-1:0] max_w;
    ticks_w = WIDE'(ticks);
    max_w   = WIDE'({TIMER_WIDTH{1'b1}});
    return (ticks_w > max_w) ? TIMER_WIDTH'(max_w) : TIMER_WIDTH'(ticks_w);
  endfunction

  assign load_inhibit = sat_load(cfg.inhibit_ticks);
  assign load_bit     = sat_load(cfg.bit_timeout_ticks);
  assign load_start   = sat_load(cfg.start_timeout_ticks);
  assign att_inc      = attempts_done + 4'd1;

  // next state for one beat
  always_comb begin
    phase_next            = phase;
    receive_position_next = receive_position;
    receive_shift_next    = receive_shift;
    send_position_next    = send_position;
    send_shift_next       = send_shift;
    countdown_next        = countdown;
    countdown_active_next = countdown_active;
    attempts_done_next    = attempts_done;
    clock_low_next        = clock_low_reg;
    data_low_next         = data_low_reg;
    ev                    = EV_NONE;
    rx                    = 8'd0;
    fail                  = 1'b0;

    case (command)
      CMD_EDGE: begin
        if (phase == PH_RECEIVE) begin
          if (receive_position == 4'd0) begin
            // start bit must be low
            if (!data_line) begin
              receive_position_next = 4'd1;
              countdown_next        = load_bit;
              countdown_active_next = 1'b1;
            end
          end else if (receive_position <= 4'd8) begin
            receive_shift_next    = receive_shift |
                                    (8'(data_line) << (receive_position - 4'd1));
            receive_position_next = receive_position + 4'd1;
            countdown_next        = load_bit;
            countdown_active_next = 1'b1;
          end else if (receive_position == POS_PARITY) begin
            receive_position_next = POS_STOP;
            countdown_next        = load_bit;
            countdown_active_next = 1'b1;
          end else begin
            // stop position delivers the byte, anything beyond restarts
            if (receive_position == POS_STOP) begin
              ev = EV_BYTE;
              rx = receive_shift;
            end
            receive_position_next = 4'd0;
            receive_shift_next    = 8'd0;
            countdown_next        = '0;
            countdown_active_next = 1'b0;
          end
        end else if (phase == PH_SEND) begin
          if (send_position >= 4'd1 && send_position <= 4'd8) begin
            data_low_next         = ~send_shift[3'(send_position - 4'd1)];
            send_position_next    = send_position + 4'd1;
            countdown_next        = load_bit;
            countdown_active_next = 1'b1;
          end else if (send_position == POS_PARITY) begin
            // odd parity bit low when the byte has odd weight
            data_low_next         = ^send_shift;
            send_position_next    = POS_STOP;
            countdown_next        = load_bit;
            countdown_active_next = 1'b1;
          end else if (send_position == POS_STOP) begin
            data_low_next         = 1'b0;
            send_position_next    = POS_ACK;
            countdown_next        = load_bit;
            countdown_active_next = 1'b1;
          end else if (send_position == POS_ACK && !data_line) begin
            phase_next            = PH_RECEIVE;
            clock_low_next        = 1'b0;
            data_low_next         = 1'b0;
            countdown_active_next = 1'b0;
            countdown_next        = '0;
            attempts_done_next    = 4'd0;
            send_position_next    = 4'd0;
            receive_position_next = 4'd0;
            receive_shift_next    = 8'd0;
            ev                    = EV_SEND_OK;
          end else begin
            fail = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (countdown_active) begin
          if (countdown > TIMER_WIDTH'(1)) begin
            countdown_next = countdown - TIMER_WIDTH'(1);
          end else begin
            countdown_next        = '0;
            countdown_active_next = 1'b0;
            if (phase == PH_RECEIVE) begin
              receive_position_next = 4'd0;
              receive_shift_next    = 8'd0;
              ev                    = EV_ABORT;
            end else if (phase == PH_INHIBIT) begin
              // release clock, drive start bit
              phase_next            = PH_SEND;
              clock_low_next        = 1'b0;
              data_low_next         = 1'b1;
              send_position_next    = 4'd1;
              countdown_next        = load_start;
              countdown_active_next = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
        end
      end
      CMD_SEND: begin
        if (phase != PH_RECEIVE) begin
          ev = EV_BUSY;
        end else begin
          receive_position_next = 4'd0;
          receive_shift_next    = 8'd0;
          send_shift_next       = send_value;
          attempts_done_next    = 4'd0;
          phase_next            = PH_INHIBIT;
          clock_low_next        = 1'b1;
          data_low_next         = 1'b0;
          send_position_next    = 4'd0;
          countdown_next        = load_inhibit;
          countdown_active_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // failed attempt: retry or give up
    if (fail) begin
      if (att_inc >= cfg.max_attempts || att_inc == 4'd0) begin
        phase_next            = PH_RECEIVE;
        clock_low_next        = 1'b0;
        data_low_next         = 1'b0;
        countdown_active_next = 1'b0;
        countdown_next        = '0;
        attempts_done_next    = 4'd0;
        send_position_next    = 4'd0;
        receive_position_next = 4'd0;
        receive_shift_next    = 8'd0;
        ev                    = EV_SEND_FAIL;
      end else begin
        attempts_done_next    = att_inc;
        phase_next            = PH_INHIBIT;
        clock_low_next        = 1'b1;
        data_low_next         = 1'b0;
        send_position_next    = 4'd0;
        countdown_next        = load_inhibit;
        countdown_active_next = 1'b1;
      end
    end
  end

  // result seen after the beat
  always_comb begin
    result.event_res       = ev;
    result.received_value  = rx;
    result.clock_drive_low = clock_low_next;
    result.data_drive_low  = data_low_next;
    result.busy_res        = (phase_next != PH_RECEIVE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RECEIVE;
      receive_position <= 4'd0;
      receive_shift    <= 8'd0;
      send_position    <= 4'd0;
      send_shift       <= 8'd0;
      countdown        <= '0;
      countdown_active <= 1'b0;
      attempts_done    <= 4'd0;
      clock_low_reg    <= 1'b0;
      data_low_reg     <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      receive_position <= receive_position_next;
      receive_shift    <= receive_shift_next;
      send_position    <= send_position_next;
      send_shift       <= send_shift_next;
      countdown        <= countdown_next;
      countdown_active <= countdown_active_next;
      attempts_done    <= attempts_done_next;
      clock_low_reg    <= clock_low_next;
      data_low_reg     <= data_low_next;
    end
  end

endmodule

/* sv/ps2_host_line_controller.sv */
// top level of the ps/2 host line controller
// holds the configuration registers and the two-entry result buffer
// depends on ps2hlc_pkg, ps2hlc_if and ps2hlc_step
//
//   channel  direction  payload                                    beats
//   req      sink       command, data_line, send_value             one per item
//   rsp      source     event_res, received_value, line drive, busy one per item
//   cfg      write      cfg_we, cfg_index, cfg_data                one per register
//
// each request beat is folded into the line state in the cycle it is accepted and its
// result is registered in the result register or the skid entry; one beat per cycle
// while req ready is high. the result register plus a skid entry keeps req ready
// through a single rsp stall; req ready drops only while the skid entry is full.
// synchronous reset clears line state and loads the default timings.

module ps2_host_line_controller #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  ps2hlc_req_if.sink  req,
  ps2hlc_rsp_if.source rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ps2hlc_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    accept, pop;

  assign req.ready = ~skid_valid;
  assign accept    = req.valid & req.ready;
  assign pop       = out_valid & rsp.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inhibit_ticks       <= INHIBIT_RESET;
      cfg.bit_timeout_ticks   <= BIT_TIMEOUT_RESET;
      cfg.start_timeout_ticks <= START_TIMEOUT_RESET;
      cfg.max_attempts        <= MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INHIBIT:       cfg.inhibit_ticks       <= cfg_data;
        REG_BIT_TIMEOUT:   cfg.bit_timeout_ticks   <= cfg_data;
        REG_START_TIMEOUT: cfg.start_timeout_ticks <= cfg_data;
        REG_MAX_ATTEMPTS:  cfg.max_attempts        <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  ps2hlc_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (accept),
    .command    (req.command),
    .data_line  (req.data_line),
    .send_value (req.send_value),
    .result     (step_result)
  );

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_data <= step_result;
      end else begin
        skid_data <= step_result;
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.event_res       = out_data.event_res;
  assign rsp.received_value  = out_data.received_value;
  assign rsp.clock_drive_low = out_data.clock_drive_low;
  assign rsp.data_drive_low  = out_data.data_drive_low;
  assign rsp.busy_res        = out_data.busy_res;

endmodule
